// ===== src/pjb_pkg.sv =====
// ----------------------------------------------------------------------------
// pjb_pkg
// Shared types and constants for the playout jitter buffer.
// ----------------------------------------------------------------------------
package pjb_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int REG_W       = 5;
   // width for comparing register values against counts
   localparam int EXT_W       = (CNT_W > REG_W) ? CNT_W : REG_W;

   localparam logic [1:0] OP_PUSH  = 2'd0;
   localparam logic [1:0] OP_POP   = 2'd1;
   localparam logic [1:0] OP_FLUSH = 2'd2;

   localparam logic REG_TARGET = 1'b0;
   localparam logic REG_MAX    = 1'b1;

   typedef struct packed {
      logic [31:0] seq;
      logic [31:0] handle;
   } pjb_frame_type;

   typedef struct packed {
      logic             shift;
      logic             write;
      logic [IDX_W-1:0] wr_index;
   } pjb_row_ctrl_type;

endpackage

// ===== src/pjb_cell.sv =====
// ----------------------------------------------------------------------------
// pjb_cell
// One queue slot: loads a new frame or takes its upstream neighbor's frame.
// ----------------------------------------------------------------------------
module pjb_cell (
   input  logic                  clock,
   input  logic                  shift,
   input  logic                  load,
   input  pjb_pkg::pjb_frame_type upstream,
   input  pjb_pkg::pjb_frame_type new_frame,
   output pjb_pkg::pjb_frame_type frame
);
   import pjb_pkg::*;

   pjb_frame_type frame_ff;
   pjb_frame_type frame_in;

   always_comb begin
      frame_in = frame_ff;
      if (load) begin
         frame_in = new_frame;
      end else if (shift) begin
         frame_in = upstream;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff <= frame_in;
   end

   assign frame = frame_ff;

endmodule

// ===== src/pjb_cell_row.sv =====
// ----------------------------------------------------------------------------
// pjb_cell_row
// Row of queue cells; cell 0 is the head, frames move toward it on a shift.
// ----------------------------------------------------------------------------
module pjb_cell_row (
   input  logic                     clock,
   input  pjb_pkg::pjb_row_ctrl_type ctrl,
   input  pjb_pkg::pjb_frame_type    new_frame,
   output pjb_pkg::pjb_frame_type    head
);
   import pjb_pkg::*;

   pjb_frame_type cell_q [QUEUE_DEPTH];

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      pjb_frame_type upstream;
      logic          load;

      if (i == QUEUE_DEPTH - 1) begin : g_tail
         assign upstream = cell_q[i];
      end else begin : g_mid
         assign upstream = cell_q[i+1];
      end

      // write position is already in post-shift coordinates
      assign load = ctrl.write && (ctrl.wr_index == IDX_W'(i));

      pjb_cell u_cell (
         .clock     (clock),
         .shift     (ctrl.shift),
         .load      (load),
         .upstream  (upstream),
         .new_frame (new_frame),
         .frame     (cell_q[i])
      );
   end

   assign head = cell_q[0];

endmodule

// ===== src/playout_jitter_buffer.sv =====
// ----------------------------------------------------------------------------
// playout_jitter_buffer
// Jitter buffer of frame descriptors with push, pop and flush commands.
// ----------------------------------------------------------------------------
// The result strobe is registered and rises in the cycle after start is taken.
// Throughput: one command per cycle; busy is never asserted. The queue is a
//   shifting row of cells, so push, eviction and pop act on all cells in parallel.
// Reset clears queue state, statistics and registers (target 3, max 8) at once.
// Results cannot be stalled by the receiver.
module playout_jitter_buffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_opcode,
   input  logic [31:0] req_frame_sequence,
   input  logic [31:0] req_frame_handle,
   output logic        rsp_valid,
   output logic        rsp_push_accepted,
   output logic        rsp_pop_valid,
   output logic [31:0] rsp_out_sequence,
   output logic [31:0] rsp_out_handle,
   output logic [4:0]  rsp_queue_depth,
   output logic        rsp_is_primed,
   output logic [31:0] rsp_dropped_count,
   output logic [31:0] rsp_pushed_count,
   output logic [31:0] rsp_popped_count,
   output logic [31:0] rsp_underrun_count,
   output logic [4:0]  rsp_high_watermark,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pjb_pkg::*;

   logic [REG_W-1:0] target_ff, target_in;
   logic [REG_W-1:0] max_ff, max_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] peak_ff, peak_in;
   logic             primed_ff, primed_in;
   logic             last_valid_ff, last_valid_in;
   logic [31:0]      last_seq_ff, last_seq_in;
   logic [31:0]      drop_ff, drop_in;
   logic [31:0]      push_ff, push_in;
   logic [31:0]      pop_ff, pop_in;
   logic [31:0]      under_ff, under_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             accepted_ff, accepted_in;
   logic             popped_ff, popped_in;
   logic [31:0]      oseq_ff, oseq_in;
   logic [31:0]      ohdl_ff, ohdl_in;

   logic             take;
   logic             csr_write;
   logic [EXT_W-1:0] eff_target;
   logic [EXT_W-1:0] eff_limit;
   logic [EXT_W-1:0] count_ext;
   logic             evict;
   logic [CNT_W-1:0] count_kept;
   pjb_row_ctrl_type row_ctrl;
   pjb_frame_type    new_frame;
   pjb_frame_type    head;

   assign take      = start && !busy;
   assign busy      = 1'b0;
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // effective target and limit, both clamped to the storage depth
   always_comb begin
      eff_target = EXT_W'(target_ff);
      if (eff_target == '0) begin
         eff_target = EXT_W'(1);
      end
      if (eff_target > EXT_W'(QUEUE_DEPTH)) begin
         eff_target = EXT_W'(QUEUE_DEPTH);
      end
      eff_limit = (EXT_W'(max_ff) > eff_target) ? EXT_W'(max_ff) : eff_target;
      if (eff_limit > EXT_W'(QUEUE_DEPTH)) begin
         eff_limit = EXT_W'(QUEUE_DEPTH);
      end
   end

   assign count_ext  = EXT_W'(count_ff);
   assign evict      = (count_ext >= eff_limit) && (count_ff != '0);
   assign count_kept = count_ff - CNT_W'(evict);
   assign new_frame  = '{seq: req_frame_sequence, handle: req_frame_handle};

   always_comb begin
      count_in      = count_ff;
      peak_in       = peak_ff;
      primed_in     = primed_ff;
      last_valid_in = last_valid_ff;
      last_seq_in   = last_seq_ff;
      drop_in       = drop_ff;
      push_in       = push_ff;
      pop_in        = pop_ff;
      under_in      = under_ff;
      accepted_in   = 1'b0;
      popped_in     = 1'b0;
      oseq_in       = '0;
      ohdl_in       = '0;
      row_ctrl      = '{shift: 1'b0, write: 1'b0, wr_index: '0};

      if (take) begin
         case (req_opcode)
            OP_PUSH: begin
               if (last_valid_ff && (req_frame_sequence <= last_seq_ff)) begin
                  drop_in = drop_ff + 32'd1;
               end else begin
                  last_valid_in = 1'b1;
                  last_seq_in   = req_frame_sequence;
                  count_in      = count_kept;
                  if (evict) begin
                     row_ctrl.shift = 1'b1;
                     drop_in        = drop_ff + 32'd1;
                  end
                  if (count_kept < CNT_W'(QUEUE_DEPTH)) begin
                     row_ctrl.write    = 1'b1;
                     row_ctrl.wr_index = IDX_W'(count_kept);
                     count_in          = count_kept + CNT_W'(1);
                  end
                  push_in = push_ff + 32'd1;
                  if (count_in > peak_ff) begin
                     peak_in = count_in;
                  end
                  if (EXT_W'(count_in) >= eff_target) begin
                     primed_in = 1'b1;
                  end
                  accepted_in = 1'b1;
               end
            end
            OP_POP: begin
               if (!primed_ff || (count_ff == '0)) begin
                  primed_in = 1'b0;
                  under_in  = under_ff + 32'd1;
               end else begin
                  oseq_in        = head.seq;
                  ohdl_in        = head.handle;
                  popped_in      = 1'b1;
                  row_ctrl.shift = 1'b1;
                  count_in       = count_ff - CNT_W'(1);
                  pop_in         = pop_ff + 32'd1;
                  if (count_in == '0) begin
                     primed_in = 1'b0;
                  end
               end
            end
            OP_FLUSH: begin
               primed_in     = 1'b0;
               last_valid_in = 1'b0;
               last_seq_in   = '0;
               count_in      = '0;
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      target_in = target_ff;
      max_in    = max_ff;
      if (csr_write) begin
         case (paddr[2])
            REG_TARGET: target_in = pwdata[REG_W-1:0];
            default:    max_in    = pwdata[REG_W-1:0];
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_TARGET: prdata = 32'(target_ff);
         default:    prdata = 32'(max_ff);
      endcase
   end

   assign rsp_valid_in = take;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= REG_W'(3);
         max_ff        <= REG_W'(8);
         count_ff      <= '0;
         peak_ff       <= '0;
         primed_ff     <= 1'b0;
         last_valid_ff <= 1'b0;
         last_seq_ff   <= '0;
         drop_ff       <= '0;
         push_ff       <= '0;
         pop_ff        <= '0;
         under_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         target_ff     <= target_in;
         max_ff        <= max_in;
         count_ff      <= count_in;
         peak_ff       <= peak_in;
         primed_ff     <= primed_in;
         last_valid_ff <= last_valid_in;
         last_seq_ff   <= last_seq_in;
         drop_ff       <= drop_in;
         push_ff       <= push_in;
         pop_ff        <= pop_in;
         under_ff      <= under_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      accepted_ff <= accepted_in;
      popped_ff   <= popped_in;
      oseq_ff     <= oseq_in;
      ohdl_ff     <= ohdl_in;
   end

   pjb_cell_row u_row (
      .clock     (clock),
      .ctrl      (row_ctrl),
      .new_frame (new_frame),
      .head      (head)
   );

   // state registers hold the post-transaction values during the result cycle
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_push_accepted  = accepted_ff;
   assign rsp_pop_valid      = popped_ff;
   assign rsp_out_sequence   = oseq_ff;
   assign rsp_out_handle     = ohdl_ff;
   assign rsp_queue_depth    = 5'(count_ff);
   assign rsp_is_primed      = primed_ff;
   assign rsp_dropped_count  = drop_ff;
   assign rsp_pushed_count   = push_ff;
   assign rsp_popped_count   = pop_ff;
   assign rsp_underrun_count = under_ff;
   assign rsp_high_watermark = 5'(peak_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count exceeds storage");

   a_primed_nonempty: assert property (@(posedge clock) disable iff (reset)
      primed_ff |-> (count_ff != '0))
      else $error("primed with empty queue");

   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(accepted_ff && popped_ff))
      else $error("push and pop reported together");

   a_peak_tracks: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff)
      else $error("watermark below current depth");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the playout jitter buffer. A short directed table
// of commands runs first, then random push/pop/flush traffic over a series
// of depth settings. A local model of the queue predicts each response that
// the table does not give itself, and each response strobe is compared field
// by field against the oldest pending expectation.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import pjb_pkg::*;

   localparam logic [1:0] OP_NOP      = 2'd3;
   localparam logic [2:0] ADDR_TARGET = {REG_TARGET, 2'b00};
   localparam logic [2:0] ADDR_MAX    = {REG_MAX, 2'b00};
   localparam int DIR_N       = 25;
   localparam int N_PHASES    = 10;
   localparam int PHASE_ITEMS = 153;
   localparam int STALL_LIMIT = 300;
   localparam int EXP_DEPTH   = 8;

   typedef struct packed {
      logic        push_accepted;
      logic        pop_valid;
      logic [31:0] out_sequence;
      logic [31:0] out_handle;
      logic [4:0]  queue_depth;
      logic        is_primed;
      logic [31:0] dropped_count;
      logic [31:0] pushed_count;
      logic [31:0] popped_count;
      logic [31:0] underrun_count;
      logic [4:0]  high_watermark;
   } jb_result_type;

   typedef struct packed {
      logic [1:0]    op;
      logic [31:0]   seq;
      logic [31:0]   hdl;
      logic          typed;
      jb_result_type want;
   } dir_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_opcode;
   logic [31:0] req_frame_sequence;
   logic [31:0] req_frame_handle;
   logic        rsp_valid;
   logic        rsp_push_accepted;
   logic        rsp_pop_valid;
   logic [31:0] rsp_out_sequence;
   logic [31:0] rsp_out_handle;
   logic [4:0]  rsp_queue_depth;
   logic        rsp_is_primed;
   logic [31:0] rsp_dropped_count;
   logic [31:0] rsp_pushed_count;
   logic [31:0] rsp_popped_count;
   logic [31:0] rsp_underrun_count;
   logic [4:0]  rsp_high_watermark;
   logic        psel;
   logic        penable;
   logic        pwrite;
   logic [2:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   playout_jitter_buffer u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_frame_sequence (req_frame_sequence),
      .req_frame_handle   (req_frame_handle),
      .rsp_valid          (rsp_valid),
      .rsp_push_accepted  (rsp_push_accepted),
      .rsp_pop_valid      (rsp_pop_valid),
      .rsp_out_sequence   (rsp_out_sequence),
      .rsp_out_handle     (rsp_out_handle),
      .rsp_queue_depth    (rsp_queue_depth),
      .rsp_is_primed      (rsp_is_primed),
      .rsp_dropped_count  (rsp_dropped_count),
      .rsp_pushed_count   (rsp_pushed_count),
      .rsp_popped_count   (rsp_popped_count),
      .rsp_underrun_count (rsp_underrun_count),
      .rsp_high_watermark (rsp_high_watermark),
      .psel               (psel),
      .penable            (penable),
      .pwrite             (pwrite),
      .paddr              (paddr),
      .pwdata             (pwdata),
      .prdata             (prdata),
      .pready             (pready)
   );

   // ---------------- queue model ----------------
   pjb_frame_type frame_ring [QUEUE_DEPTH];
   int            ring_head  = 0;
   int            ring_count = 0;
   int            ring_peak  = 0;
   logic          armed      = 1'b0;
   logic          seq_seen   = 1'b0;
   logic [31:0]   newest_seq = '0;
   logic [31:0]   n_dropped  = '0;
   logic [31:0]   n_pushed   = '0;
   logic [31:0]   n_popped   = '0;
   logic [31:0]   n_underrun = '0;
   logic [4:0]    cfg_target = 5'd3;
   logic [4:0]    cfg_max    = 5'd8;

   // predictions waiting for their response strobe
   jb_result_type exp_ring [EXP_DEPTH];
   int            exp_rd       = 0;
   int            exp_wr       = 0;
   int            exp_level    = 0;
   int            err_count    = 0;
   int            quiet_cycles = 0;
   logic          cur_typed    = 1'b0;
   jb_result_type cur_want     = '0;

   function automatic void exp_put(input jb_result_type r);
      exp_ring[exp_wr] = r;
      exp_wr           = (exp_wr + 1) % EXP_DEPTH;
      exp_level++;
   endfunction

   function automatic jb_result_type exp_take();
      jb_result_type r;
      r      = exp_ring[exp_rd];
      exp_rd = (exp_rd + 1) % EXP_DEPTH;
      exp_level--;
      return r;
   endfunction

   function automatic int arm_level();
      int t;
      t = int'(cfg_target);
      if (t < 1) t = 1;
      if (t > QUEUE_DEPTH) t = QUEUE_DEPTH;
      return t;
   endfunction

   function automatic int queue_limit();
      int t;
      int m;
      t = arm_level();
      m = (int'(cfg_max) > t) ? int'(cfg_max) : t;
      if (m > QUEUE_DEPTH) m = QUEUE_DEPTH;
      return m;
   endfunction

   function automatic jb_result_type next_buffer_state(input logic [1:0] op,
                                                       input logic [31:0] seq,
                                                       input logic [31:0] hdl);
      jb_result_type r;
      int wr;
      r = '0;
      case (op)
         OP_PUSH: begin
            if (seq_seen && seq <= newest_seq) begin
               n_dropped++;
            end else begin
               seq_seen   = 1'b1;
               newest_seq = seq;
               // full at the limit: oldest frame makes room, one at most
               if (ring_count >= queue_limit() && ring_count > 0) begin
                  ring_head = (ring_head + 1) % QUEUE_DEPTH;
                  ring_count--;
                  n_dropped++;
               end
               if (ring_count < QUEUE_DEPTH) begin
                  wr = (ring_head + ring_count) % QUEUE_DEPTH;
                  frame_ring[wr].seq    = seq;
                  frame_ring[wr].handle = hdl;
                  ring_count++;
               end
               n_pushed++;
               if (ring_count > ring_peak) ring_peak = ring_count;
               if (!armed && ring_count >= arm_level()) armed = 1'b1;
               r.push_accepted = 1'b1;
            end
         end
         OP_POP: begin
            if (!armed) begin
               n_underrun++;
            end else if (ring_count == 0) begin
               armed = 1'b0;
               n_underrun++;
            end else begin
               r.out_sequence = frame_ring[ring_head].seq;
               r.out_handle   = frame_ring[ring_head].handle;
               r.pop_valid    = 1'b1;
               ring_head      = (ring_head + 1) % QUEUE_DEPTH;
               ring_count--;
               n_popped++;
               if (ring_count == 0) armed = 1'b0;
            end
         end
         OP_FLUSH: begin
            armed      = 1'b0;
            seq_seen   = 1'b0;
            newest_seq = '0;
            ring_count = 0;
            ring_head  = 0;
         end
         default: begin
         end
      endcase
      r.queue_depth    = 5'(ring_count);
      r.is_primed      = armed;
      r.dropped_count  = n_dropped;
      r.pushed_count   = n_pushed;
      r.popped_count   = n_popped;
      r.underrun_count = n_underrun;
      r.high_watermark = 5'(ring_peak);
      return r;
   endfunction

   // ---------------- checking ----------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      err_count++;
      $display("tb: mismatch at %0t on %s: got %h, want %h", $realtime, what, got, want);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch(name, got, want);
   endtask

   task automatic check_result(input jb_result_type got, input jb_result_type want);
      check_field("push_accepted", 32'(got.push_accepted), 32'(want.push_accepted));
      check_field("pop_valid", 32'(got.pop_valid), 32'(want.pop_valid));
      check_field("out_sequence", got.out_sequence, want.out_sequence);
      check_field("out_handle", got.out_handle, want.out_handle);
      check_field("queue_depth", 32'(got.queue_depth), 32'(want.queue_depth));
      check_field("is_primed", 32'(got.is_primed), 32'(want.is_primed));
      check_field("dropped_count", got.dropped_count, want.dropped_count);
      check_field("pushed_count", got.pushed_count, want.pushed_count);
      check_field("popped_count", got.popped_count, want.popped_count);
      check_field("underrun_count", got.underrun_count, want.underrun_count);
      check_field("high_watermark", 32'(got.high_watermark), 32'(want.high_watermark));
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // response check first, then predict the transaction taken at this edge
   always @(posedge clock) begin
      jb_result_type got;
      jb_result_type pred;
      if (!reset) begin
         if (rsp_valid) begin
            got = {rsp_push_accepted, rsp_pop_valid, rsp_out_sequence, rsp_out_handle,
                   rsp_queue_depth, rsp_is_primed, rsp_dropped_count, rsp_pushed_count,
                   rsp_popped_count, rsp_underrun_count, rsp_high_watermark};
            if (exp_level == 0)
               report_mismatch("unexpected response, depth", 32'(got.queue_depth), 32'd0);
            else
               check_result(got, exp_take());
         end
         if (start && !busy) begin
            pred = next_buffer_state(req_opcode, req_frame_sequence, req_frame_handle);
            if (exp_level >= EXP_DEPTH)
               report_mismatch("prediction overflow, level", 32'(exp_level), 32'd0);
            else
               exp_put(cur_typed ? cur_want : pred);
         end
         if (rsp_valid || (start && !busy))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: done, errors");
            $finish;
         end
      end
   end

   // ---------------- driving ----------------
   // entered and left at a falling edge
   task automatic send_item(input logic [1:0] op, input logic [31:0] seq,
                            input logic [31:0] hdl, input logic typed,
                            input jb_result_type want);
      start              <= 1'b1;
      req_opcode         <= op;
      req_frame_sequence <= seq;
      req_frame_handle   <= hdl;
      cur_typed          = typed;
      cur_want           = want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic idle_for(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (exp_level != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [4:0] val);
      logic [31:0] rd;
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= {27'd0, val};
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rd = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (addr == ADDR_TARGET)
         cfg_target = val;
      else
         cfg_max = val;
      if (rd !== {27'd0, val}) report_mismatch("register readback", rd, {27'd0, val});
   endtask

   dir_row_type dir_tab [DIR_N];
   int ph_target [7] = '{3, 0, 31, 1, 16, 1, 17};
   int ph_max    [7] = '{8, 0, 0, 31, 16, 1, 2};
   int ph_push   [N_PHASES] = '{55, 60, 80, 50, 80, 40, 55, 55, 50, 55};

   initial begin
      logic [1:0]  op;
      logic [31:0] seq;
      logic [31:0] hdl;
      logic [31:0] gen_last;
      int          roll;
      int          idle_pct;

      reset              = 1'b1;
      start              = 1'b0;
      req_opcode         = OP_NOP;
      req_frame_sequence = '0;
      req_frame_handle   = '0;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;

      dir_tab = '{
         '{OP_POP, 32'h0, 32'h0, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 5'd0}},
         '{OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd0, 1'b0, 32'd0, 32'd0, 32'd0, 32'd1, 5'd0}},
         '{OP_PUSH, 32'h0, 32'h0, 1'b1,
           '{1'b1, 1'b0, 32'h0, 32'h0, 5'd1, 1'b0, 32'd0, 32'd1, 32'd0, 32'd1, 5'd1}},
         // equal sequence is stale
         '{OP_PUSH, 32'h0, 32'h1234_5678, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd1, 1'b0, 32'd1, 32'd1, 32'd0, 32'd1, 5'd1}},
         '{OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
           '{1'b1, 1'b0, 32'h0, 32'h0, 5'd2, 1'b0, 32'd1, 32'd2, 32'd0, 32'd1, 5'd2}},
         '{OP_PUSH, 32'h5, 32'h0, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd2, 1'b0, 32'd2, 32'd2, 32'd0, 32'd1, 5'd2}},
         // below target: underrun even with frames held
         '{OP_POP, 32'h0, 32'h0, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd2, 1'b0, 32'd2, 32'd2, 32'd0, 32'd2, 5'd2}},
         '{OP_FLUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd0, 1'b0, 32'd2, 32'd2, 32'd0, 32'd2, 5'd2}},
         '{OP_PUSH, 32'h0, 32'hA5A5_A5A5, 1'b1,
           '{1'b1, 1'b0, 32'h0, 32'h0, 5'd1, 1'b0, 32'd2, 32'd3, 32'd0, 32'd2, 5'd2}},
         '{OP_PUSH, 32'h1, 32'h5A5A_5A5A, 1'b1,
           '{1'b1, 1'b0, 32'h0, 32'h0, 5'd2, 1'b0, 32'd2, 32'd4, 32'd0, 32'd2, 5'd2}},
         '{OP_PUSH, 32'h2, 32'h0000_FFFF, 1'b1,
           '{1'b1, 1'b0, 32'h0, 32'h0, 5'd3, 1'b1, 32'd2, 32'd5, 32'd0, 32'd2, 5'd3}},
         '{OP_POP, 32'h0, 32'h0, 1'b1,
           '{1'b0, 1'b1, 32'h0, 32'hA5A5_A5A5, 5'd2, 1'b1, 32'd2, 32'd5, 32'd1, 32'd2, 5'd3}},
         '{OP_POP, 32'h0, 32'h0, 1'b1,
           '{1'b0, 1'b1, 32'h1, 32'h5A5A_5A5A, 5'd1, 1'b1, 32'd2, 32'd5, 32'd2, 32'd2, 5'd3}},
         // drains to empty and disarms
         '{OP_POP, 32'h0, 32'h0, 1'b1,
           '{1'b0, 1'b1, 32'h2, 32'h0000_FFFF, 5'd0, 1'b0, 32'd2, 32'd5, 32'd3, 32'd2, 5'd3}},
         '{OP_POP, 32'h0, 32'h0, 1'b1,
           '{1'b0, 1'b0, 32'h0, 32'h0, 5'd0, 1'b0, 32'd2, 32'd5, 32'd3, 32'd3, 5'd3}},
         // run past the default limit of 8 to force an eviction
         '{OP_PUSH, 32'd100, 32'h1000_0001, 1'b0, '0},
         '{OP_PUSH, 32'd101, 32'h2000_0002, 1'b0, '0},
         '{OP_PUSH, 32'd102, 32'h3000_0003, 1'b0, '0},
         '{OP_PUSH, 32'd103, 32'h4000_0004, 1'b0, '0},
         '{OP_PUSH, 32'd104, 32'h5000_0005, 1'b0, '0},
         '{OP_PUSH, 32'd105, 32'h6000_0006, 1'b0, '0},
         '{OP_PUSH, 32'd106, 32'h7000_0007, 1'b0, '0},
         '{OP_PUSH, 32'd107, 32'h8000_0008, 1'b0, '0},
         '{OP_PUSH, 32'd108, 32'h9000_0009, 1'b0, '0},
         '{OP_POP, 32'h0, 32'h0, 1'b0, '0}
      };

      repeat (10) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < DIR_N; i++)
         send_item(dir_tab[i].op, dir_tab[i].seq, dir_tab[i].hdl, dir_tab[i].typed,
                   dir_tab[i].want);

      gen_last = 32'd200;
      idle_pct = 0;
      for (int ph = 0; ph < N_PHASES; ph++) begin
         wait_drained();
         if (ph < 7) begin
            csr_write(ADDR_TARGET, 5'(ph_target[ph]));
            csr_write(ADDR_MAX, 5'(ph_max[ph]));
         end else begin
            csr_write(ADDR_TARGET, 5'($urandom_range(0, 31)));
            csr_write(ADDR_MAX, 5'($urandom_range(0, 31)));
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % 50 == 0)
               idle_pct = (ph == N_PHASES - 1) ? 0 : 10 * int'($urandom_range(0, 2));
            if (int'($urandom_range(0, 99)) < idle_pct)
               idle_for(int'($urandom_range(1, 18)));
            hdl  = $urandom();
            roll = int'($urandom_range(0, 99));
            if (roll < ph_push[ph]) begin
               op   = OP_PUSH;
               roll = int'($urandom_range(0, 99));
               if (roll < 84)
                  seq = gen_last + $urandom_range(1, 4000);
               else if (roll < 90)
                  seq = gen_last;
               else
                  seq = $urandom();
               if (seq > gen_last) gen_last = seq;
            end else if (roll < 95) begin
               op  = OP_POP;
               seq = $urandom();
            end else if (roll < 98) begin
               op       = OP_FLUSH;
               seq      = $urandom();
               gen_last = $urandom() >> $urandom_range(0, 31);
            end else begin
               op  = OP_NOP;
               seq = $urandom();
            end
            send_item(op, seq, hdl, 1'b0, '0);
         end
      end

      start <= 1'b0;
      while (exp_level != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (err_count == 0)
         $display("tb: done, clean");
      else
         $display("tb: done, errors");
      $finish;
   end

endmodule
